### hw/rtl/usp_pkg.sv
package usp_pkg;

    // Field widths of the stream words.
    localparam int SPAN_W    = 10;
    localparam int SECTOR_W  = 11;
    localparam int POS_W     = 16;
    localparam int TEX_W     = 16;
    localparam int INDEX_W   = 20;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 128;

    // Grid limits used for clamping the configuration.
    localparam int MAX_SECTORS_DEF = 1024;
    localparam int MAX_SPANS_DEF   = 512;

    // Configuration register indexes and reset values.
    localparam logic CFG_SECTOR_COUNT = 1'b0;
    localparam logic CFG_SPAN_COUNT   = 1'b1;
    localparam logic [SECTOR_W-1:0] SECTOR_COUNT_RST = 11'd36;
    localparam logic [SPAN_W-1:0]   SPAN_COUNT_RST   = 10'd18;

    // Fixed-point constants.
    localparam logic [63:0] PI_Q30     = 64'd3373259426;
    localparam logic [63:0] TWO_PI_Q30 = PI_Q30 * 64'd2;
    localparam logic [TEX_W-1:0] TEX_ONE = 16'd32768;

    // Pipelined divider geometry.
    localparam int DIV_NUM_W = 44;
    localparam int DIV_DEN_W = 11;
    localparam int DIV_BPS   = 4;
    localparam int DIV_LAT   = (DIV_NUM_W + DIV_BPS - 1) / DIV_BPS;

    // CORDIC geometry: angle rounding, range reduction, iterations, final fixup.
    localparam int ANG_IN_W  = 34;
    localparam int ANG_W     = 19;
    localparam int Z_W       = 21;
    localparam int XY_W      = 33;
    localparam int TRIG_W    = 32;
    localparam int COR_ITERS = 16;
    localparam int COR_IPS   = 2;
    localparam int COR_LAT   = COR_ITERS / COR_IPS + 3;

    localparam logic signed [Z_W-1:0] PI_Q16      = Z_W'((PI_Q30 + 64'd8192) >> 14);
    localparam logic signed [Z_W-1:0] HALF_PI_Q16 = Z_W'((PI_Q30 + 64'd16384) >> 15);
    localparam logic signed [Z_W-1:0] TWO_PI_Q16  = Z_W'((PI_Q30 + 64'd4096) >> 13);
    localparam logic signed [XY_W-1:0] GAIN_Q30   = 33'sd652032874;
    localparam logic signed [XY_W-1:0] ONE_Q30    = 33'sd1073741824;

    localparam logic signed [Z_W-1:0] ATAN_Q16 [COR_ITERS] = '{
        21'sd51472, 21'sd30386, 21'sd16055, 21'sd8150,
        21'sd4091,  21'sd2047,  21'sd1024,  21'sd512,
        21'sd256,   21'sd128,   21'sd64,    21'sd32,
        21'sd16,    21'sd8,     21'sd4,     21'sd2
    };

    // Sideband that rides beside the dividers.
    typedef struct packed {
        logic               valid;
        logic               in_grid;
        logic               upper;
        logic               lower;
        logic [INDEX_W-1:0] k1;
        logic [INDEX_W-1:0] k2;
    } side_t;

    // Sideband that rides beside the CORDIC units.
    typedef struct packed {
        side_t            base;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } side2_t;

endpackage

### hw/rtl/usp_delay.sv
module usp_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [W-1:0] d_in,
    output logic [W-1:0] d_out
);

    logic [W-1:0] line_reg [DEPTH];

    // Shift line that advances with the pipeline enable.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DEPTH; k++) begin
                line_reg[k] <= '0;
            end
        end else if (en) begin
            line_reg[0] <= d_in;
            for (int k = 1; k < DEPTH; k++) begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign d_out = line_reg[DEPTH-1];

endmodule

### hw/rtl/usp_div.sv
module usp_div #(
    parameter int NUM_W = 44,
    parameter int DEN_W = 11,
    parameter int BPS   = 4
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W-1:0] den_in,
    output logic [NUM_W-1:0] quo_out
);

    localparam int STAGES = (NUM_W + BPS - 1) / BPS;
    localparam int PAD_W  = STAGES * BPS;

    logic [DEN_W-1:0] rem_reg [STAGES];
    logic [PAD_W-1:0] num_reg [STAGES];
    logic [PAD_W-1:0] quo_reg [STAGES];
    logic [DEN_W-1:0] den_reg [STAGES];

    // Restoring division, BPS quotient bits per register stage.
    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [DEN_W-1:0] rem_i;
        logic [PAD_W-1:0] num_i;
        logic [PAD_W-1:0] quo_i;
        logic [DEN_W-1:0] den_i;
        logic [DEN_W-1:0] r;
        logic [PAD_W-1:0] n;
        logic [PAD_W-1:0] q;
        logic [DEN_W:0]   trial;

        if (s == 0) begin : g_first
            assign rem_i = '0;
            assign num_i = PAD_W'(num_in);
            assign quo_i = '0;
            assign den_i = den_in;
        end else begin : g_next
            assign rem_i = rem_reg[s-1];
            assign num_i = num_reg[s-1];
            assign quo_i = quo_reg[s-1];
            assign den_i = den_reg[s-1];
        end

        always_comb begin
            r = rem_i;
            n = num_i;
            q = quo_i;
            trial = '0;
            for (int t = 0; t < BPS; t++) begin
                trial = {r, n[PAD_W-1]};
                n = {n[PAD_W-2:0], 1'b0};
                if (trial >= {1'b0, den_i}) begin
                    r = DEN_W'(trial - {1'b0, den_i});
                    q = {q[PAD_W-2:0], 1'b1};
                end else begin
                    r = trial[DEN_W-1:0];
                    q = {q[PAD_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= r;
                num_reg[s] <= n;
                quo_reg[s] <= q;
                den_reg[s] <= den_i;
            end
        end
    end

    assign quo_out = quo_reg[STAGES-1][NUM_W-1:0];

endmodule

### hw/rtl/usp_cordic.sv
module usp_cordic (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic [usp_pkg::ANG_IN_W-1:0]         angle_in,
    output logic signed [usp_pkg::TRIG_W-1:0]    cos_out,
    output logic signed [usp_pkg::TRIG_W-1:0]    sin_out
);

    localparam int STAGES = usp_pkg::COR_ITERS / usp_pkg::COR_IPS;
    localparam int IPS    = usp_pkg::COR_IPS;
    localparam int Z_W    = usp_pkg::Z_W;
    localparam int XY_W   = usp_pkg::XY_W;
    localparam int TRIG_W = usp_pkg::TRIG_W;

    logic [usp_pkg::ANG_W-1:0] ang_reg;
    logic signed [Z_W-1:0]     zred_reg;
    logic                      negred_reg;
    logic signed [XY_W-1:0]    x_reg [STAGES];
    logic signed [XY_W-1:0]    y_reg [STAGES];
    logic signed [Z_W-1:0]     z_reg [STAGES];
    logic                      neg_reg [STAGES];
    logic signed [TRIG_W-1:0]  cos_reg;
    logic signed [TRIG_W-1:0]  sin_reg;

    logic [usp_pkg::ANG_IN_W:0] ang_sum;
    logic signed [Z_W-1:0]      a_wrap;
    logic signed [Z_W-1:0]      a_red;
    logic                       neg_red;

    // Round the Q30 angle to Q16 radians.
    assign ang_sum = (usp_pkg::ANG_IN_W+1)'(angle_in) + (usp_pkg::ANG_IN_W+1)'(8192);

    // Bring the angle into [-pi/2, pi/2], noting a sign flip of the results.
    always_comb begin
        a_wrap = Z_W'(signed'({2'b00, ang_reg}));
        if (a_wrap > usp_pkg::PI_Q16) begin
            a_wrap = a_wrap - usp_pkg::TWO_PI_Q16;
        end
        a_red = a_wrap;
        neg_red = 1'b0;
        if (a_wrap > usp_pkg::HALF_PI_Q16) begin
            a_red = a_wrap - usp_pkg::PI_Q16;
            neg_red = 1'b1;
        end else if (a_wrap < -usp_pkg::HALF_PI_Q16) begin
            a_red = a_wrap + usp_pkg::PI_Q16;
            neg_red = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg    <= ang_sum[usp_pkg::ANG_W+13:14];
            zred_reg   <= a_red;
            negred_reg <= neg_red;
        end
    end

    // Rotation-mode iterations, IPS per register stage.
    for (genvar s = 0; s < STAGES; s++) begin : g_iter
        logic signed [XY_W-1:0] x_i;
        logic signed [XY_W-1:0] y_i;
        logic signed [Z_W-1:0]  z_i;
        logic                   neg_i;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;

        if (s == 0) begin : g_first
            assign x_i   = usp_pkg::GAIN_Q30;
            assign y_i   = '0;
            assign z_i   = zred_reg;
            assign neg_i = negred_reg;
        end else begin : g_next
            assign x_i   = x_reg[s-1];
            assign y_i   = y_reg[s-1];
            assign z_i   = z_reg[s-1];
            assign neg_i = neg_reg[s-1];
        end

        always_comb begin
            x = x_i;
            y = y_i;
            z = z_i;
            dx = '0;
            dy = '0;
            for (int t = 0; t < IPS; t++) begin
                dx = y >>> (s * IPS + t);
                dy = x >>> (s * IPS + t);
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - usp_pkg::ATAN_Q16[s * IPS + t];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + usp_pkg::ATAN_Q16[s * IPS + t];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[s]   <= x;
                y_reg[s]   <= y;
                z_reg[s]   <= z;
                neg_reg[s] <= neg_i;
            end
        end
    end

    logic signed [XY_W-1:0] x_f;
    logic signed [XY_W-1:0] y_f;

    // Undo the half-turn and clamp to the unit range.
    always_comb begin
        x_f = neg_reg[STAGES-1] ? -x_reg[STAGES-1] : x_reg[STAGES-1];
        y_f = neg_reg[STAGES-1] ? -y_reg[STAGES-1] : y_reg[STAGES-1];
        if (x_f > usp_pkg::ONE_Q30) begin
            x_f = usp_pkg::ONE_Q30;
        end else if (x_f < -usp_pkg::ONE_Q30) begin
            x_f = -usp_pkg::ONE_Q30;
        end
        if (y_f > usp_pkg::ONE_Q30) begin
            y_f = usp_pkg::ONE_Q30;
        end else if (y_f < -usp_pkg::ONE_Q30) begin
            y_f = -usp_pkg::ONE_Q30;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= TRIG_W'(x_f);
            sin_reg <= TRIG_W'(y_f);
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;

endmodule

### hw/rtl/uv_sphere_point_generator_top.sv
// Channel   Dir  Handshake          Word contents (lowest bit first)
// s_        in   s_tvalid/s_tready  span_index[9:0], sector_index[20:10]
// m_        out  m_tvalid/m_tready  pos_x, pos_y, pos_z, tex_u, tex_v, vertex_index,
//                                   next_row_index, upper/lower_tri_valid, point_in_grid
// cfg_      in   cfg_wr_en          register index cfg_addr, value cfg_wdata
//
// One word is taken every cycle while no result waits on a low m_tready.
// The pipeline is the input register, the 11-stage dividers, the 11-stage CORDIC
// units, one multiply stage and the output register.
// Reset (aresetn low, synchronous) empties the pipeline and loads 36 sectors, 18 spans.
// When m_tready is low with a result waiting, every stage holds its word.
module uv_sphere_point_generator_top #(
    parameter int MAX_SECTORS = usp_pkg::MAX_SECTORS_DEF,
    parameter int MAX_SPANS   = usp_pkg::MAX_SPANS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic                           cfg_addr,
    input  logic [usp_pkg::SECTOR_W-1:0]   cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // span_index [9:0], sector_index [20:10], zero [23:21]
    input  logic [usp_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // pos_x [15:0], pos_y [31:16], pos_z [47:32], tex_u [63:48], tex_v [79:64],
    // vertex_index [99:80], next_row_index [119:100], upper_tri_valid [120],
    // lower_tri_valid [121], point_in_grid [122], zero [127:123]
    output logic [usp_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int SPAN_W   = usp_pkg::SPAN_W;
    localparam int SECTOR_W = usp_pkg::SECTOR_W;
    localparam int NUM_W    = usp_pkg::DIV_NUM_W;
    localparam int DEN_W    = usp_pkg::DIV_DEN_W;
    localparam int INDEX_W  = usp_pkg::INDEX_W;
    localparam int TRIG_W   = usp_pkg::TRIG_W;

    logic [SECTOR_W-1:0] sector_count_reg;
    logic [SPAN_W-1:0]   span_count_reg;
    logic                en;
    logic                m_tvalid_reg;
    logic [usp_pkg::M_DATA_W-1:0] m_tdata_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_count_reg <= usp_pkg::SECTOR_COUNT_RST;
            span_count_reg   <= usp_pkg::SPAN_COUNT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                usp_pkg::CFG_SECTOR_COUNT: sector_count_reg <= cfg_wdata;
                usp_pkg::CFG_SPAN_COUNT:   span_count_reg   <= cfg_wdata[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves while the output register is free or being taken.
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    logic [SPAN_W-1:0]   span_i;
    logic [SECTOR_W-1:0] sector_j;
    logic [SECTOR_W-1:0] sectors_c;
    logic [SPAN_W-1:0]   spans_c;
    logic [INDEX_W-1:0]  sec_p1;
    logic [INDEX_W-1:0]  k1;
    usp_pkg::side_t      side_in;

    assign span_i   = s_tdata[SPAN_W-1:0];
    assign sector_j = s_tdata[SPAN_W+SECTOR_W-1:SPAN_W];

    // Clamp the configured grid to its legal range.
    always_comb begin
        sectors_c = sector_count_reg;
        if (sector_count_reg < SECTOR_W'(2)) begin
            sectors_c = SECTOR_W'(2);
        end else if (32'(sector_count_reg) > MAX_SECTORS) begin
            sectors_c = SECTOR_W'(MAX_SECTORS);
        end
        spans_c = span_count_reg;
        if (span_count_reg < SPAN_W'(1)) begin
            spans_c = SPAN_W'(1);
        end else if (32'(span_count_reg) > MAX_SPANS) begin
            spans_c = SPAN_W'(MAX_SPANS);
        end
    end

    // Indexes and triangle flags of the grid point.
    assign sec_p1 = INDEX_W'(sectors_c) + INDEX_W'(1);
    assign k1     = INDEX_W'(span_i) * sec_p1 + INDEX_W'(sector_j);

    always_comb begin
        side_in.valid   = s_tvalid;
        side_in.in_grid = (span_i <= spans_c) && (sector_j <= sectors_c);
        side_in.upper   = (span_i != '0) && (span_i < spans_c) && (sector_j < sectors_c);
        side_in.lower   = ((SECTOR_W'(span_i) + SECTOR_W'(1)) < SECTOR_W'(spans_c))
                          && (sector_j < sectors_c);
        side_in.k1      = k1;
        side_in.k2      = k1 + sec_p1;
    end

    // Input stage: numerators for the angle and texture divisions.
    logic [NUM_W-1:0] span_num_reg;
    logic [NUM_W-1:0] sec_num_reg;
    logic [NUM_W-1:0] u_num_reg;
    logic [NUM_W-1:0] v_num_reg;
    logic [DEN_W-1:0] sec_den_reg;
    logic [DEN_W-1:0] span_den_reg;
    usp_pkg::side_t   side1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            span_num_reg <= NUM_W'(usp_pkg::PI_Q30) * NUM_W'(spans_c - span_i);
            sec_num_reg  <= NUM_W'(usp_pkg::TWO_PI_Q30) * NUM_W'(sector_j);
            u_num_reg    <= NUM_W'({sector_j, 15'b0}) + NUM_W'(sectors_c >> 1);
            v_num_reg    <= NUM_W'({span_i, 15'b0}) + NUM_W'(spans_c >> 1);
            sec_den_reg  <= DEN_W'(sectors_c);
            span_den_reg <= DEN_W'(spans_c);
        end
    end

    // Valid bit and sideband of the input stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side1_reg <= '0;
        end else if (en) begin
            side1_reg <= side_in;
        end
    end

    // Four dividers of equal latency.
    logic [NUM_W-1:0] span_q;
    logic [NUM_W-1:0] sec_q;
    logic [NUM_W-1:0] u_q;
    logic [NUM_W-1:0] v_q;

    usp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .BPS(usp_pkg::DIV_BPS)) u_div_span (
        .aclk(aclk), .en(en), .num_in(span_num_reg), .den_in(span_den_reg), .quo_out(span_q)
    );
    usp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .BPS(usp_pkg::DIV_BPS)) u_div_sec (
        .aclk(aclk), .en(en), .num_in(sec_num_reg), .den_in(sec_den_reg), .quo_out(sec_q)
    );
    usp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .BPS(usp_pkg::DIV_BPS)) u_div_u (
        .aclk(aclk), .en(en), .num_in(u_num_reg), .den_in(sec_den_reg), .quo_out(u_q)
    );
    usp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .BPS(usp_pkg::DIV_BPS)) u_div_v (
        .aclk(aclk), .en(en), .num_in(v_num_reg), .den_in(span_den_reg), .quo_out(v_q)
    );

    usp_pkg::side_t side1_d;

    usp_delay #(.W($bits(usp_pkg::side_t)), .DEPTH(usp_pkg::DIV_LAT)) u_delay_div (
        .aclk(aclk), .aresetn(aresetn), .en(en), .d_in(side1_reg), .d_out(side1_d)
    );

    // Saturate the texture coordinates at 1.0.
    usp_pkg::side2_t side2_in;
    usp_pkg::side2_t side2_d;

    always_comb begin
        side2_in.base  = side1_d;
        side2_in.tex_u = (u_q > NUM_W'(usp_pkg::TEX_ONE)) ? usp_pkg::TEX_ONE
                                                          : usp_pkg::TEX_W'(u_q);
        side2_in.tex_v = (v_q > NUM_W'(usp_pkg::TEX_ONE)) ? usp_pkg::TEX_ONE
                                                          : usp_pkg::TEX_W'(v_q);
    end

    // Sine and cosine of both angles.
    logic signed [TRIG_W-1:0] span_cos;
    logic signed [TRIG_W-1:0] span_sin;
    logic signed [TRIG_W-1:0] sec_cos;
    logic signed [TRIG_W-1:0] sec_sin;

    usp_cordic u_cordic_span (
        .aclk(aclk), .en(en), .angle_in(usp_pkg::ANG_IN_W'(span_q)),
        .cos_out(span_cos), .sin_out(span_sin)
    );
    usp_cordic u_cordic_sec (
        .aclk(aclk), .en(en), .angle_in(usp_pkg::ANG_IN_W'(sec_q)),
        .cos_out(sec_cos), .sin_out(sec_sin)
    );

    usp_delay #(.W($bits(usp_pkg::side2_t)), .DEPTH(usp_pkg::COR_LAT)) u_delay_cor (
        .aclk(aclk), .aresetn(aresetn), .en(en), .d_in(side2_in), .d_out(side2_d)
    );

    // Ring radius times the sector cosine and sine.
    logic signed [63:0]       prod_x_reg;
    logic signed [63:0]       prod_z_reg;
    logic signed [TRIG_W-1:0] cy_reg;
    usp_pkg::side2_t          side3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_x_reg <= 64'(span_sin) * 64'(sec_cos);
            prod_z_reg <= 64'(span_sin) * 64'(sec_sin);
            cy_reg     <= span_cos;
        end
    end

    // Valid bit and sideband of the multiply stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side3_reg <= '0;
        end else if (en) begin
            side3_reg <= side2_d;
        end
    end

    function automatic logic [usp_pkg::POS_W-1:0] clamp_q14(input logic signed [63:0] v);
        if (v > 64'sd16384) begin
            return usp_pkg::POS_W'(16384);
        end else if (v < -64'sd16384) begin
            return usp_pkg::POS_W'(-16384);
        end
        return v[usp_pkg::POS_W-1:0];
    endfunction

    // Round to Q14, clamp, and blank points outside the grid.
    logic signed [63:0] py_full;
    logic signed [63:0] px_full;
    logic signed [63:0] pz_full;
    logic [usp_pkg::M_DATA_W-1:0] word;

    always_comb begin
        py_full = (64'(cy_reg) + 64'sd32768) >>> 16;
        px_full = (prod_x_reg + (64'sd1 <<< 45)) >>> 46;
        pz_full = (prod_z_reg + (64'sd1 <<< 45)) >>> 46;
        word = '0;
        if (side3_reg.base.in_grid) begin
            word[15:0]    = clamp_q14(px_full);
            word[31:16]   = clamp_q14(py_full);
            word[47:32]   = clamp_q14(pz_full);
            word[63:48]   = side3_reg.tex_u;
            word[79:64]   = side3_reg.tex_v;
            word[99:80]   = side3_reg.base.k1;
            word[119:100] = side3_reg.base.k2;
            word[120]     = side3_reg.base.upper;
            word[121]     = side3_reg.base.lower;
            word[122]     = 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= side3_reg.base.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
